@@ hdl/ntcdti_pkg.sv @@
`timescale 1ns / 1ps

package ntcdti_pkg;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned SHIFT_W   = 4;
	localparam int unsigned BITS_W    = 5;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned TEMP_W    = 17;
	// signed resistance: quotient below 2^33 minus series resistance
	localparam int unsigned R_W       = 35;
	// divider: numerator up to 5 * 2^33, denominator a sample or a table span
	localparam int unsigned NUM_W     = 36;
	localparam int unsigned DEN_W     = 20;
	localparam int unsigned OHMS_W    = 21;

	localparam int unsigned TABLE_ENTRIES = 34;
	localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

	// thermistor resistance in ohms, -40 C upward in 5 C steps
	localparam logic [OHMS_W-1:0] NTC_OHMS [TABLE_ENTRIES] = '{
		21'd1227262, 21'd874449, 21'd630851, 21'd460456, 21'd339797, 21'd253362,
		21'd190766, 21'd144963, 21'd111086, 21'd85841, 21'd66861, 21'd52470,
		21'd41470, 21'd33000, 21'd26430, 21'd21298, 21'd17265, 21'd14076,
		21'd11537, 21'd9505, 21'd7870, 21'd6549, 21'd5475, 21'd4595,
		21'd3874, 21'd3281, 21'd2788, 21'd2378, 21'd2037, 21'd1751,
		21'd1509, 21'd1305, 21'd1134, 21'd987
	};

	localparam logic signed [TEMP_W-1:0] TEMP_FIRST = -17'sd40;
	localparam logic [TEMP_W-1:0]        TEMP_STEP  = 17'd5;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -17'sd65536;
	// largest extrapolation quotient that does not take the result below TEMP_MIN
	localparam logic [NUM_W-1:0]         EXTRAP_LIMIT = 36'd65496;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_SHIFT   = 3'd0,
		CFG_SAMPLE_BITS    = 3'd1,
		CFG_USE_FIXED_REF  = 3'd2,
		CFG_FIXED_REF      = 3'd3,
		CFG_SERIES_RES     = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [SHIFT_W-1:0]  sample_shift;
		logic [BITS_W-1:0]   sample_bits;
		logic                use_fixed_reference;
		logic [SAMPLE_W-1:0] fixed_reference_value;
		logic [SAMPLE_W-1:0] series_resistance;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sample_shift:          4'd0,
		sample_bits:           5'd12,
		use_fixed_reference:   1'b0,
		fixed_reference_value: 16'd4096,
		series_resistance:     16'd2400
	};

	function automatic logic [SAMPLE_W-1:0] extract_sample(
		input logic [SAMPLE_W-1:0] word,
		input logic [SHIFT_W-1:0]  shift,
		input logic [BITS_W-1:0]   bits
	);
		logic [SAMPLE_W-1:0] mask;
		if (bits >= BITS_W'(SAMPLE_W))
			mask = '1;
		else
			mask = SAMPLE_W'((17'd1 << bits) - 17'd1);
		return (word >> shift) & mask;
	endfunction

endpackage

@@ hdl/ntc_divider_table_interpolate.sv @@
`timescale 1ns / 1ps

// NTC thermistor divider to temperature.
// Input: pulse start with mode, sensor_word and reference_word valid; the item
// is taken at a clock edge where start is high and busy is low. In mode 0, busy
// stays high until the result is out.
// Output: done is high for exactly one cycle with temperature_value (signed C,
// or the extracted sensor sample in mode 1) and out_of_table. The receiver
// cannot stall; the value must be captured on that cycle.
// Config: cfg_valid/cfg_ready write channel, cfg_index selects the register,
// cfg_data carries the value. cfg_ready is always high; write only while idle.
// Sequence: mode 1 gives done in the cycle after the transfer. Mode 0 runs a
// multiply, a 36-step shared divider pass for the resistance, a table scan of
// one entry per cycle and, unless the resistance is at or below the last
// entry, a second 36-step divider pass for the interpolation.
// busy drops as done rises, so the next transfer can take the edge ending done.
// Reset: asynchronous, active low; returns to idle and loads register defaults.
module ntc_divider_table_interpolate (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic                                     mode,
	input  logic [ntcdti_pkg::SAMPLE_W-1:0]          sensor_word,
	input  logic [ntcdti_pkg::SAMPLE_W-1:0]          reference_word,
	output logic                                     done,
	output logic signed [ntcdti_pkg::TEMP_W-1:0]     temperature_value,
	output logic                                     out_of_table,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [ntcdti_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ntcdti_pkg::SAMPLE_W-1:0]          cfg_data
);

	localparam int unsigned SAMPLE_W = ntcdti_pkg::SAMPLE_W;
	localparam int unsigned NUM_W    = ntcdti_pkg::NUM_W;
	localparam int unsigned DEN_W    = ntcdti_pkg::DEN_W;
	localparam int unsigned R_W      = ntcdti_pkg::R_W;
	localparam int unsigned TEMP_W   = ntcdti_pkg::TEMP_W;
	localparam int unsigned IDX_W    = ntcdti_pkg::IDX_W;
	localparam int unsigned OHMS_W   = ntcdti_pkg::OHMS_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ntcdti_pkg::TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV1,
		ST_SCAN,
		ST_PREP,
		ST_DIV2,
		ST_FIN
	} state_t;

	state_t state_q;

	ntcdti_pkg::cfg_t cfg;

	logic                     div_start_q;
	logic                     div_done;
	logic [NUM_W-1:0]         div_quot;

	logic                     done_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic                     flag_q;

	logic [SAMPLE_W-1:0]      sense_q;
	logic [SAMPLE_W-1:0]      ref_q;
	logic [NUM_W-1:0]         num_q;
	logic [DEN_W-1:0]         den_q;
	logic signed [R_W-1:0]    r_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     extrap_q;
	logic [NUM_W-1:0]         quot_q;

	logic [SAMPLE_W-1:0]      sense_raw;
	logic [SAMPLE_W-1:0]      ref_raw;
	logic                     accept;
	logic [IDX_W-1:0]         idx_nxt;
	logic [OHMS_W-1:0]        ohms_cur;
	logic [OHMS_W-1:0]        ohms_next;
	logic                     hit;
	logic signed [R_W-1:0]    diff;
	logic [NUM_W-1:0]         num_interp;
	logic [OHMS_W-1:0]        span;
	logic signed [TEMP_W-1:0] temp_base;
	logic signed [TEMP_W-1:0] temp_fin;

	ntcdti_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ntcdti_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (num_q),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign accept    = start && !busy;
	assign sense_raw = ntcdti_pkg::extract_sample(sensor_word, cfg.sample_shift,
		cfg.sample_bits);
	assign ref_raw   = cfg.use_fixed_reference ? cfg.fixed_reference_value :
		ntcdti_pkg::extract_sample(reference_word, cfg.sample_shift, cfg.sample_bits);

	assign idx_nxt   = (idx_q == LAST_IDX) ? idx_q : idx_q + IDX_W'(1);
	assign ohms_cur  = ntcdti_pkg::NTC_OHMS[idx_q];
	assign ohms_next = ntcdti_pkg::NTC_OHMS[idx_nxt];
	assign hit       = $signed(R_W'(ohms_cur)) >= r_q;

	// above the first entry the first segment is extended; magnitude is
	// divided and the sign applied afterwards (truncation toward zero)
	always_comb begin
		if (extrap_q) begin
			diff = r_q - $signed(R_W'(ntcdti_pkg::NTC_OHMS[0]));
			span = ntcdti_pkg::NTC_OHMS[0] - ntcdti_pkg::NTC_OHMS[1];
		end else begin
			diff = $signed(R_W'(ohms_cur)) - r_q;
			span = ohms_cur - ohms_next;
		end
	end

	assign num_interp = (NUM_W'(unsigned'(diff)) << 2) + NUM_W'(unsigned'(diff));
	assign temp_base  = ntcdti_pkg::TEMP_FIRST
		+ signed'(TEMP_W'(idx_q) * ntcdti_pkg::TEMP_STEP);

	always_comb begin
		if (!extrap_q)
			temp_fin = temp_base + signed'(TEMP_W'(quot_q));
		else if (quot_q > ntcdti_pkg::EXTRAP_LIMIT)
			temp_fin = ntcdti_pkg::TEMP_MIN;
		else
			temp_fin = ntcdti_pkg::TEMP_FIRST - signed'(TEMP_W'(quot_q));
	end

	assign busy              = state_q != ST_IDLE;
	assign done              = done_q;
	assign temperature_value = temp_q;
	assign out_of_table      = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			done_q      <= 1'b0;
			temp_q      <= '0;
			flag_q      <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode) begin
							temp_q  <= signed'(TEMP_W'(sense_raw));
							flag_q  <= 1'b0;
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (hit && idx_q == LAST_IDX) begin
						// at or below the last entry
						temp_q  <= temp_base;
						flag_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (hit || idx_q == '0) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					div_start_q <= 1'b1;
					state_q     <= ST_DIV2;
				end
				ST_DIV2: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					temp_q  <= temp_fin;
					flag_q  <= extrap_q;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sense_q  <= (sense_raw == '0) ? SAMPLE_W'(1) : sense_raw;
				ref_q    <= ref_raw;
				extrap_q <= 1'b0;
			end
			ST_MUL: begin
				num_q <= NUM_W'(cfg.series_resistance * ref_q) << 1;
				den_q <= DEN_W'(sense_q);
			end
			ST_DIV1: begin
				r_q   <= $signed(R_W'(div_quot)) - $signed(R_W'(cfg.series_resistance));
				idx_q <= LAST_IDX;
			end
			ST_SCAN: begin
				if (!hit && idx_q == '0)
					extrap_q <= 1'b1;
				else if (!hit)
					idx_q <= idx_q - IDX_W'(1);
			end
			ST_PREP: begin
				num_q <= num_interp;
				den_q <= DEN_W'(span);
			end
			ST_DIV2: begin
				quot_q <= div_quot;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_mode1_next: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode) |=> done_q && !busy)
		else $error("direct sample not returned on next cycle");

	a_mode0_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mode) |=> busy && !done_q)
		else $error("conversion did not start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while still busy");

	a_flag_cold: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && flag_q) |-> temp_q[TEMP_W-1])
		else $error("extrapolated value not below first entry");
`endif

endmodule

@@ hdl/ntcdti_cfg.sv @@
`timescale 1ns / 1ps

module ntcdti_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ntcdti_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ntcdti_pkg::SAMPLE_W-1:0]       cfg_data,
	output ntcdti_pkg::cfg_t                      cfg
);

	ntcdti_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= ntcdti_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ntcdti_pkg::CFG_SAMPLE_SHIFT:
					cfg_q.sample_shift <= cfg_data[ntcdti_pkg::SHIFT_W-1:0];
				ntcdti_pkg::CFG_SAMPLE_BITS:
					cfg_q.sample_bits <= cfg_data[ntcdti_pkg::BITS_W-1:0];
				ntcdti_pkg::CFG_USE_FIXED_REF:
					cfg_q.use_fixed_reference <= cfg_data[0];
				ntcdti_pkg::CFG_FIXED_REF:
					cfg_q.fixed_reference_value <= cfg_data;
				ntcdti_pkg::CFG_SERIES_RES:
					cfg_q.series_resistance <= cfg_data;
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == ntcdti_pkg::CFG_SAMPLE_SHIFT)
		|=> cfg_q.sample_shift == $past(cfg_data[ntcdti_pkg::SHIFT_W-1:0]))
		else $error("sample shift write lost");

	a_series_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == ntcdti_pkg::CFG_SERIES_RES)
		|=> cfg_q.series_resistance == $past(cfg_data))
		else $error("series resistance write lost");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_valid |=> $stable(cfg_q))
		else $error("config changed without a transfer");
`endif

endmodule

@@ hdl/ntcdti_div.sv @@
`timescale 1ns / 1ps

module ntcdti_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ntcdti_pkg::NUM_W-1:0]      dividend,
	input  logic [ntcdti_pkg::DEN_W-1:0]      divisor,
	output logic                              done,
	output logic [ntcdti_pkg::NUM_W-1:0]      quotient
);

	localparam int unsigned NUM_W = ntcdti_pkg::NUM_W;
	localparam int unsigned DEN_W = ntcdti_pkg::DEN_W;
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W-1:0] rem_next;

	// restoring division, one quotient bit per cycle
	assign trial    = {rem_q, quo_q[NUM_W-1]};
	assign fits     = trial >= {1'b0, den_q};
	assign rem_next = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !done_q && busy_q)
		else $error("divider finished too early");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still iterating");
`endif

endmodule
